>>> src/sdvs_pkg.sv
// ----------------------------------------------------------------------------
// sdvs_pkg
// Shared constants, codes and controller/datapath interface types for the
// sparse/dense vector subtract block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdvs_pkg;

  // Storage sizes
  localparam int DENSE_MAX   = 32;
  localparam int SPARSE_MAX  = 16;
  localparam int INDEX_WIDTH = 20;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 5;
  localparam int FIDX_W  = 20;
  localparam int VAL_W   = 32;
  localparam int OIDX_W  = 20;
  localparam int NDEN_W  = 6;
  localparam int THR_W   = 31;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 31;

  // Derived widths
  localparam int DAW = (DENSE_MAX > 1) ? $clog2(DENSE_MAX) : 1;   // dense address
  localparam int DCW = $clog2(DENSE_MAX + 1);                     // dense pointer
  localparam int SAW = (SPARSE_MAX > 1) ? $clog2(SPARSE_MAX) : 1; // sparse address
  localparam int SCW = $clog2(SPARSE_MAX + 1);                    // sparse count
  localparam int NDW = (NDEN_W > DCW) ? NDEN_W : DCW;             // dense count compare
  localparam int SLW = (SLOT_W > DCW) ? SLOT_W : DCW;             // slot compare

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WR_A  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APP_A = 3'd2;
  localparam logic [CMD_W-1:0] CMD_APP_B = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GO    = 3'd4;

  // Config register indexes
  localparam logic [CFGI_W-1:0] CFG_NUM_DENSE = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_ZERO_THR  = 2'd1;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // input word taken this cycle
    logic start;       // go accepted: rewind pointers
    logic dense_step;  // produce next dense difference
    logic merge_step;  // advance sparse merge by one step
    logic flush;       // emit final word, clear sparse state
  } sdvs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic dense_done;
    logic merge_done;
    logic out_free;
  } sdvs_stat_t;

endpackage

`default_nettype wire

>>> src/sdvs_ctrl.sv
// ----------------------------------------------------------------------------
// sdvs_ctrl
// Sequencer for loads and the go walk: dense phase, merge phase, flush.
// ----------------------------------------------------------------------------
`default_nettype none

module sdvs_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [sdvs_pkg::CMD_W-1:0] cmd,
  output logic                            in_ready,
  input  wire sdvs_pkg::sdvs_stat_t       stat,
  output sdvs_pkg::sdvs_cmd_t             ctl
);
  import sdvs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DENSE,
    ST_MERGE,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.load       = in_fire;
    case (state)
      ST_IDLE: begin
        if (in_fire && (cmd == CMD_GO)) begin
          ctl.start  = 1'b1;
          state_next = ST_DENSE;
        end
      end
      ST_DENSE: begin
        if (stat.dense_done) begin
          state_next = ST_MERGE;
        end else if (stat.out_free) begin
          ctl.dense_step = 1'b1;
        end
      end
      ST_MERGE: begin
        if (stat.merge_done) begin
          state_next = ST_FLUSH;
        end else if (stat.out_free) begin
          ctl.merge_step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          ctl.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

`default_nettype wire

>>> src/sdvs_dp.sv
// ----------------------------------------------------------------------------
// sdvs_dp
// Datapath: vector stores, config registers, walk pointers, one-deep
// pending slot (for tagging last) and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdvs_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sdvs_pkg::sdvs_cmd_t         ctl,
  output sdvs_pkg::sdvs_stat_t             stat,
  input  wire logic [sdvs_pkg::CMD_W-1:0]  cmd,
  input  wire logic [sdvs_pkg::SLOT_W-1:0] slot,
  input  wire logic [sdvs_pkg::FIDX_W-1:0] feat_index,
  input  wire logic [sdvs_pkg::VAL_W-1:0]  value,
  input  wire logic                        cfg_we,
  input  wire logic [sdvs_pkg::CFGI_W-1:0] cfg_index,
  input  wire logic [sdvs_pkg::CFGD_W-1:0] cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sdvs_pkg::OIDX_W-1:0]      out_index,
  output logic [sdvs_pkg::VAL_W-1:0]       out_value,
  output logic                             last,
  output logic                             empty_res,
  output logic                             overflow
);
  import sdvs_pkg::*;

  // Stores (no reset: read only after written)
  logic [VAL_W-1:0]       dense_a [DENSE_MAX];
  logic [VAL_W-1:0]       dense_b [DENSE_MAX];
  logic [INDEX_WIDTH-1:0] sa_idx  [SPARSE_MAX];
  logic [VAL_W-1:0]       sa_val  [SPARSE_MAX];
  logic [INDEX_WIDTH-1:0] sb_idx  [SPARSE_MAX];
  logic [VAL_W-1:0]       sb_val  [SPARSE_MAX];

  logic [SCW-1:0]    a_count;
  logic [SCW-1:0]    b_count;
  logic              ovf_flag;
  logic [NDEN_W-1:0] dense_len;
  logic [THR_W-1:0]  zero_thr;

  logic [DCW-1:0] dptr;
  logic [SCW-1:0] iptr;
  logic [SCW-1:0] jptr;

  logic              pend_valid;
  logic [OIDX_W-1:0] pend_idx;
  logic [VAL_W-1:0]  pend_val;

  // Combinational step logic
  logic [NDW-1:0]         nd_wide;
  logic [DCW-1:0]         nd;
  logic                   slot_ok;
  logic                   a_more;
  logic                   b_more;
  logic [INDEX_WIDTH-1:0] ia;
  logic [INDEX_WIDTH-1:0] ib;
  logic [VAL_W-1:0]       va;
  logic [VAL_W-1:0]       vb;
  logic                   take_a;
  logic                   take_b;
  logic [VAL_W-1:0]       diff;
  logic [VAL_W-1:0]       mag;
  logic                   keep;
  logic [VAL_W-1:0]       dense_diff;
  logic                   cand_valid;
  logic [OIDX_W-1:0]      cand_idx;
  logic [VAL_W-1:0]       cand_val;

  always_comb begin
    nd_wide = (NDW'(dense_len) > NDW'(DENSE_MAX)) ? NDW'(DENSE_MAX) : NDW'(dense_len);
    nd      = DCW'(nd_wide);
    slot_ok = SLW'(slot) < SLW'(DENSE_MAX);

    dense_diff = dense_a[DAW'(dptr)] - dense_b[DAW'(dptr)];

    a_more = iptr < a_count;
    b_more = jptr < b_count;
    ia     = sa_idx[SAW'(iptr)];
    ib     = sb_idx[SAW'(jptr)];
    va     = sa_val[SAW'(iptr)];
    vb     = sb_val[SAW'(jptr)];
    if (a_more && b_more) begin
      take_a = ia <= ib;
      take_b = ib <= ia;
    end else begin
      take_a = a_more;
      take_b = !a_more;
    end
    diff = va - vb;
    mag  = diff[VAL_W-1] ? (VAL_W'(0) - diff) : diff;
    keep = mag > VAL_W'(zero_thr);

    cand_valid = 1'b0;
    cand_idx   = OIDX_W'(dptr);
    cand_val   = dense_diff;
    if (ctl.dense_step) begin
      cand_valid = 1'b1;
    end else if (ctl.merge_step) begin
      if (take_a && take_b) begin
        cand_valid = keep;
        cand_idx   = OIDX_W'(ia);
        cand_val   = diff;
      end else if (take_a) begin
        cand_valid = 1'b1;
        cand_idx   = OIDX_W'(ia);
        cand_val   = va;
      end else begin
        cand_valid = 1'b1;
        cand_idx   = OIDX_W'(ib);
        cand_val   = VAL_W'(0) - vb;
      end
    end
  end

  assign stat.dense_done = (dptr == nd);
  assign stat.merge_done = !a_more && !b_more;
  assign stat.out_free   = !out_valid || out_ready;

  // Store writes
  always_ff @(posedge clk) begin
    if (ctl.load && slot_ok && (cmd == CMD_WR_A)) begin
      dense_a[DAW'(slot)] <= value;
    end
    if (ctl.load && slot_ok && (cmd == CMD_WR_B)) begin
      dense_b[DAW'(slot)] <= value;
    end
    if (ctl.load && (cmd == CMD_APP_A) && (a_count < SCW'(SPARSE_MAX))) begin
      sa_idx[SAW'(a_count)] <= INDEX_WIDTH'(feat_index);
      sa_val[SAW'(a_count)] <= value;
    end
    if (ctl.load && (cmd == CMD_APP_B) && (b_count < SCW'(SPARSE_MAX))) begin
      sb_idx[SAW'(b_count)] <= INDEX_WIDTH'(feat_index);
      sb_val[SAW'(b_count)] <= value;
    end
  end

  // Counts, flag, config
  always_ff @(posedge clk) begin
    if (rst) begin
      a_count   <= '0;
      b_count   <= '0;
      ovf_flag  <= 1'b0;
      dense_len <= '0;
      zero_thr  <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_NUM_DENSE)) begin
        dense_len <= cfg_data[NDEN_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_ZERO_THR)) begin
        zero_thr <= cfg_data[THR_W-1:0];
      end
      if (ctl.flush) begin
        a_count  <= '0;
        b_count  <= '0;
        ovf_flag <= 1'b0;
      end else if (ctl.load && (cmd == CMD_APP_A)) begin
        if (a_count < SCW'(SPARSE_MAX)) begin
          a_count <= a_count + SCW'(1);
        end else begin
          ovf_flag <= 1'b1;
        end
      end else if (ctl.load && (cmd == CMD_APP_B)) begin
        if (b_count < SCW'(SPARSE_MAX)) begin
          b_count <= b_count + SCW'(1);
        end else begin
          ovf_flag <= 1'b1;
        end
      end
    end
  end

  // Walk pointers
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      dptr <= '0;
      iptr <= '0;
      jptr <= '0;
    end else begin
      if (ctl.dense_step) begin
        dptr <= dptr + DCW'(1);
      end
      if (ctl.merge_step && take_a) begin
        iptr <= iptr + SCW'(1);
      end
      if (ctl.merge_step && take_b) begin
        jptr <= jptr + SCW'(1);
      end
    end
  end

  // Pending slot: a result waits here until the next one (or the flush)
  // tells whether it is the final word.
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      pend_valid <= 1'b0;
    end else if (cand_valid) begin
      pend_valid <= 1'b1;
    end else if (ctl.flush) begin
      pend_valid <= 1'b0;
    end
    if (cand_valid) begin
      pend_idx <= cand_idx;
      pend_val <= cand_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cand_valid && pend_valid) || ctl.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cand_valid && pend_valid) begin
      out_index <= pend_idx;
      out_value <= pend_val;
      last      <= 1'b0;
      empty_res <= 1'b0;
      overflow  <= ovf_flag;
    end else if (ctl.flush) begin
      out_index <= pend_valid ? pend_idx : '0;
      out_value <= pend_valid ? pend_val : '0;
      last      <= 1'b1;
      empty_res <= !pend_valid;
      overflow  <= ovf_flag;
    end
  end

endmodule

`default_nettype wire

>>> src/sparse_dense_vector_subtract_top.sv
// ----------------------------------------------------------------------------
// sparse_dense_vector_subtract_top
// Loads two feature vectors (dense + sorted sparse parts) and on go emits
// A - B: dense differences by position, then a two-pointer sparse merge.
// ----------------------------------------------------------------------------
//  channel | signals                                     | dir | word
//  --------+---------------------------------------------+-----+-------------------
//  in      | in_valid in_ready cmd slot feat_index value | in  | load or go command
//  out     | out_valid out_ready out_index out_value     | out | one difference
//          | last empty_res overflow                     |     |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data      | in  | register write
//
//  A go takes min(dense count, DENSE_MAX) dense steps plus one step per sparse
//  merge pick (at most the two counts summed), then phase changes and a flush;
//  the merge makes one pick per cycle while the output is free (out_ready).
//  Reset clears sparse counts, overflow flag, config and out_valid;
//  the vector stores are not cleared.
//  out_ready low freezes the walk; in_ready stays low until the go finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_dense_vector_subtract_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input command channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [sdvs_pkg::CMD_W-1:0]  cmd,
  input  wire logic [sdvs_pkg::SLOT_W-1:0] slot,
  input  wire logic [sdvs_pkg::FIDX_W-1:0] feat_index,
  input  wire logic signed [sdvs_pkg::VAL_W-1:0] value,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sdvs_pkg::OIDX_W-1:0]      out_index,
  output logic signed [sdvs_pkg::VAL_W-1:0] out_value,
  output logic                             last,
  output logic                             empty_res,
  output logic                             overflow,
  // config write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sdvs_pkg::CFGI_W-1:0] cfg_index,
  input  wire logic [sdvs_pkg::CFGD_W-1:0] cfg_data
);
  import sdvs_pkg::*;

  sdvs_cmd_t          ctl;
  sdvs_stat_t         stat;
  logic [VAL_W-1:0]   out_value_raw;

  // Config writes land any cycle; they are to be issued only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;
  assign out_value = out_value_raw;

  sdvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  sdvs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cmd        (cmd),
    .slot       (slot),
    .feat_index (feat_index),
    .value      (value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_index  (out_index),
    .out_value  (out_value_raw),
    .last       (last),
    .empty_res  (empty_res),
    .overflow   (overflow)
  );

endmodule

`default_nettype wire
